/* rtl/sald_pkg.sv */
// ----------------------------------------------------------------------------
// sald_pkg
// Shared constants, types and command/status bundles for the LRU tag directory.
// ----------------------------------------------------------------------------
package sald_pkg;

    localparam int ADDR_BITS    = 24;
    localparam int MAX_SET_BITS = 10;
    localparam int MAX_WAYS     = 8;
    localparam int NUM_ROWS     = 1 << MAX_SET_BITS;
    localparam int WAY_W        = $clog2(MAX_WAYS);
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int SHIFT_W      = CFG_W + 1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
    localparam logic [CFG_W-1:0] SET_BITS_RST    = 4'd6;
    localparam logic [CFG_W-1:0] WAYS_IN_USE_RST = 4'd4;

    // access kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] tag;
    } entry_t;

    typedef entry_t [MAX_WAYS-1:0] row_t;

    // controller to datapath
    typedef struct packed {
        logic clear;   // write one zero row of the clearing pass
        logic accept;  // latch the transaction and read its set row
        logic commit;  // write back the reordered row on a hit or load, load the result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } sts_t;

endpackage

/* rtl/sald_ctrl.sv */
// ----------------------------------------------------------------------------
// sald_ctrl
// Controller: clearing pass after reset, accept, lookup and result handoff.
// ----------------------------------------------------------------------------
module sald_ctrl
    import sald_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_comb begin
        cmd.clear  = (state_reg == ST_CLEAR);
        cmd.accept = (state_reg == ST_IDLE) && s_valid;
        cmd.commit = (state_reg == ST_LOOKUP) && (!m_valid_reg || m_ready);

        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // wait here while the previous result is still not taken
                if (cmd.commit) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

/* rtl/sald_datapath.sv */
// ----------------------------------------------------------------------------
// sald_datapath
// Configuration registers, address split, set row memory, way compare and
// LRU reorder of the row.
// ----------------------------------------------------------------------------
module sald_datapath
    import sald_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_op,
    input  logic [ADDR_BITS-1:0] s_address,
    output logic                 m_is_hit,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int ROW_IDX_W = MAX_SET_BITS;

    logic [CFG_W-1:0]     offset_bits_reg;
    logic [CFG_W-1:0]     set_bits_reg;
    logic [CFG_W-1:0]     ways_in_use_reg;
    logic [ROW_IDX_W-1:0] clr_cnt_reg;

    logic [CFG_W-1:0]     sb_eff;
    logic [CFG_W-1:0]     ways_eff;
    logic [SHIFT_W-1:0]   tag_shift;
    logic [ADDR_BITS-1:0] row_full;
    logic [ROW_IDX_W-1:0] row_mask;
    logic [ROW_IDX_W-1:0] rd_row;
    logic [ADDR_BITS-1:0] acc_tag;

    logic                 op_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [ROW_IDX_W-1:0] row_reg;
    row_t                 rdata_reg;
    logic                 hit_reg;

    row_t                 mem [NUM_ROWS];

    logic [MAX_WAYS-1:0]  match;
    logic                 hit;
    logic [WAY_W-1:0]     found;
    logic [CFG_W-1:0]     move_lim;
    row_t                 new_row;
    logic                 wr_en;
    logic [ROW_IDX_W-1:0] wr_row;
    row_t                 wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= OFFSET_BITS_RST;
            set_bits_reg    <= SET_BITS_RST;
            ways_in_use_reg <= WAYS_IN_USE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_wdata;
                CFG_SET_BITS:    set_bits_reg    <= cfg_wdata;
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // effective settings
    always_comb begin
        if (set_bits_reg > CFG_W'(MAX_SET_BITS)) begin
            sb_eff = CFG_W'(MAX_SET_BITS);
        end else begin
            sb_eff = set_bits_reg;
        end
        if (ways_in_use_reg == '0) begin
            ways_eff = CFG_W'(1);
        end else if (ways_in_use_reg > CFG_W'(MAX_WAYS)) begin
            ways_eff = CFG_W'(MAX_WAYS);
        end else begin
            ways_eff = ways_in_use_reg;
        end
    end

    // address split of the incoming transaction
    always_comb begin
        tag_shift = SHIFT_W'(offset_bits_reg) + SHIFT_W'(sb_eff);
        row_full  = s_address >> offset_bits_reg;
        row_mask  = ROW_IDX_W'((1 << sb_eff) - 1);
        rd_row    = row_full[ROW_IDX_W-1:0] & row_mask;
        if (tag_shift >= SHIFT_W'(ADDR_BITS)) begin
            acc_tag = '0;
        end else begin
            acc_tag = s_address >> tag_shift;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= s_op;
            tag_reg   <= acc_tag;
            row_reg   <= rd_row;
            rdata_reg <= mem[rd_row];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == ROW_IDX_W'(NUM_ROWS - 1));

    // parallel compare over the searched ways
    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            match[i] = (CFG_W'(i) < ways_eff) && rdata_reg[i].valid &&
                       (rdata_reg[i].tag == tag_reg);
        end
        hit   = |match;
        found = '0;
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if (match[i]) begin
                found = WAY_W'(i);
            end
        end
    end

    // entries up to move_lim slide back one place, the accessed tag goes first
    always_comb begin
        if (hit) begin
            move_lim = CFG_W'(found);
        end else begin
            move_lim = ways_eff - 1'b1;
        end
        new_row[0].valid = 1'b1;
        new_row[0].tag   = tag_reg;
        for (int i = 1; i < MAX_WAYS; i++) begin
            if (CFG_W'(i) <= move_lim) begin
                new_row[i] = rdata_reg[i-1];
            end else begin
                new_row[i] = rdata_reg[i];
            end
        end
    end

    always_comb begin
        wr_en   = cmd.clear || (cmd.commit && (hit || (op_reg == OP_LOAD)));
        wr_row  = cmd.clear ? clr_cnt_reg : row_reg;
        wr_data = cmd.clear ? row_t'('0) : new_row;
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            hit_reg <= hit;
        end
    end

    assign m_is_hit = hit_reg;

endmodule

/* rtl/set_assoc_lru_tag_directory_top.sv */
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_directory_top
// Tag directory of a set-associative cache, true LRU, write-no-allocate.
// ----------------------------------------------------------------------------
// Usage:
// - input channel s_*: one transaction carries s_op (0 load, 1 store) and a
//   24-bit byte address; result channel m_*: m_is_hit per transaction.
// - configuration: cfg_wr_en/cfg_index/cfg_wdata write offset_bits (0),
//   set_bits (1), ways_in_use (2); write only while the block is idle.
// - each access: the set row is read from the row memory on the accept edge,
//   then compared in the lookup state and written back on a hit or a load;
//   the lookup waits while an earlier result is still not taken. s_ready
//   rises again on the edge that loads the result, so a new transaction is
//   accepted only after the previous lookup finishes; m_valid rises then too.
// - the result sits in an output register; a new transaction is accepted
//   while it waits. If the receiver still stalls when the next lookup
//   finishes, the block holds that lookup until m_ready.
// - reset: configuration returns to 4/6/4 and a clearing pass zeroes all
//   1024 set rows, one row a cycle; s_ready stays low until the pass ends.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_directory_top
    import sald_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [ADDR_BITS-1:0] s_address,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_is_hit
);

    cmd_t cmd;
    sts_t sts;

    sald_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sald_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_op      (s_op),
        .s_address (s_address),
        .m_is_hit  (m_is_hit),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* rtl/sald_checker.sv */
// ----------------------------------------------------------------------------
// sald_checker
// Port-level checks of the tag directory, bound to the top level.
// ----------------------------------------------------------------------------
module sald_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_is_hit
);

    // stalled result is held
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_hit))
        else $error("result dropped or changed while stalled");

    // one transaction in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a second transaction during lookup");

    // clearing pass blocks input after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("input open or result shown right after reset");

    // a new result only comes out of a lookup, never from idle
    a_result_from_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a lookup");

endmodule

bind set_assoc_lru_tag_directory_top sald_checker u_sald_checker (.*);

/* verif/set_assoc_lru_tag_directory_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_directory_top_test
// Self-checking test of the LRU tag directory: a local directory model
// predicts is_hit per access. The test runs directed LRU and eviction
// sequences, configuration extremes and random traffic under several idle
// and backpressure patterns.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_directory_top_test;
    import sald_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_op      = OP_LOAD;
    logic [ADDR_BITS-1:0] s_address = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_is_hit;

    // local copy of the directory and its settings
    entry_t           dir_row [NUM_ROWS][MAX_WAYS];
    logic [CFG_W-1:0] cur_offset_bits;
    logic [CFG_W-1:0] cur_set_bits;
    logic [CFG_W-1:0] cur_ways;

    logic expected_hits[$];
    logic next_hit;
    int   fail_count         = 0;
    int   sender_idle_pct    = 0;
    int   receiver_stall_pct = 0;
    int   hold_cycles        = 0;

    set_assoc_lru_tag_directory_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_address (s_address),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_is_hit  (m_is_hit)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned eff_set_bits();
        return (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cur_set_bits;
    endfunction

    function automatic int unsigned eff_ways();
        if (cur_ways < 1) return 1;
        if (cur_ways > MAX_WAYS) return MAX_WAYS;
        return cur_ways;
    endfunction

    // lookup and LRU update of one access, returns the hit flag
    function automatic logic predict_hit(logic is_store, logic [ADDR_BITS-1:0] addr);
        int unsigned          sb;
        int unsigned          ways;
        int unsigned          shift;
        int unsigned          row;
        int                   found;
        int                   i;
        logic [ADDR_BITS-1:0] tag;
        logic                 hit;
        sb    = eff_set_bits();
        ways  = eff_ways();
        shift = cur_offset_bits + sb;
        tag   = (shift >= ADDR_BITS) ? '0 : addr >> shift;
        row   = (addr >> cur_offset_bits) & ((1 << sb) - 1);
        hit   = 1'b0;
        found = 0;
        for (i = 0; i < ways; i++) begin
            if (!hit && dir_row[row][i].valid && dir_row[row][i].tag == tag) begin
                hit   = 1'b1;
                found = i;
            end
        end
        if (hit) begin
            for (i = found; i > 0; i--) dir_row[row][i] = dir_row[row][i-1];
            dir_row[row][0] = '{valid: 1'b1, tag: tag};
        end else if (is_store == OP_LOAD) begin
            for (i = ways - 1; i > 0; i--) dir_row[row][i] = dir_row[row][i-1];
            dir_row[row][0] = '{valid: 1'b1, tag: tag};
        end
        return hit;
    endfunction

    // address that lands on one of a few sets with one of a few tags
    function automatic logic [ADDR_BITS-1:0] make_address(int unsigned tag_base);
        int unsigned sb;
        int unsigned shift;
        int unsigned set_idx;
        int unsigned tag_idx;
        int unsigned off;
        logic [31:0] word;
        sb      = eff_set_bits();
        shift   = cur_offset_bits + sb;
        set_idx = $urandom_range(0, (sb < 2) ? (1 << sb) - 1 : 3);
        tag_idx = $urandom_range(0, eff_ways() + 1);
        off     = $urandom & ((1 << cur_offset_bits) - 1);
        word    = (set_idx << cur_offset_bits) | off;
        if (shift < ADDR_BITS) word = word | ((tag_base + tag_idx) << shift);
        return word[ADDR_BITS-1:0];
    endfunction

    // predictor follows every accepted transaction and register write
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            expected_hits.push_back(predict_hit(s_op, s_address));
        if (aresetn && cfg_wr_en) begin
            case (cfg_index)
                CFG_OFFSET_BITS: cur_offset_bits = cfg_wdata;
                CFG_SET_BITS:    cur_set_bits    = cfg_wdata;
                CFG_WAYS_IN_USE: cur_ways        = cfg_wdata;
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual is_hit %0b",
                         $time, m_is_hit);
                fail_count++;
            end else begin
                next_hit = expected_hits.pop_front();
                if (m_is_hit !== next_hit) begin
                    $display("%0t: is_hit mismatch, expected %0b, actual %0b",
                             $time, next_hit, m_is_hit);
                    fail_count++;
                end
            end
        end
    end

    // receiver: long hold-off when requested, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    task automatic send_access(input logic op, input logic [ADDR_BITS-1:0] addr);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_address <= addr;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_hits.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] sb,
                              input logic [CFG_W-1:0] ways);
        write_reg(CFG_OFFSET_BITS, ob);
        write_reg(CFG_SET_BITS, sb);
        write_reg(CFG_WAYS_IN_USE, ways);
    endtask

    task automatic send_random(input int unsigned tag_base);
        logic                 op;
        logic [ADDR_BITS-1:0] addr;
        op   = ($urandom_range(0, 99) < 30) ? OP_STORE : OP_LOAD;
        addr = ($urandom_range(0, 99) < 20) ? ADDR_BITS'($urandom) : make_address(tag_base);
        send_access(op, addr);
    endtask

    // reset settings 4/6/4, traffic mostly in set 5, then sets 0 and 63
    task automatic test_lru_order();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_access(OP_LOAD,  24'h000450);
        send_access(OP_LOAD,  24'h00045F);
        send_access(OP_STORE, 24'h000850);  // store miss, no allocation
        send_access(OP_LOAD,  24'h000850);
        send_access(OP_LOAD,  24'h000C50);
        send_access(OP_LOAD,  24'h001050);
        send_access(OP_STORE, 24'h000450);  // store hit moves to front
        send_access(OP_LOAD,  24'h001450);  // evicts the least recent
        send_access(OP_LOAD,  24'h000850);
        send_access(OP_LOAD,  24'h000000);
        send_access(OP_LOAD,  24'hFFFFFF);
        send_access(OP_STORE, 24'hFFFFFF);
        send_access(OP_STORE, 24'h000000);
    endtask

    task automatic test_config_extremes();
        wait_results_drained();
        set_config(4'd0, 4'd0, 4'd1);
        send_access(OP_LOAD, 24'h123456);
        send_access(OP_LOAD, 24'h123456);
        send_access(OP_LOAD, 24'h123457);
        send_access(OP_LOAD, 24'h123456);
        wait_results_drained();
        set_config(4'd12, 4'd10, 4'd8);
        send_access(OP_LOAD,  24'hABC123);
        send_access(OP_STORE, 24'hABCFFF);
        send_access(OP_LOAD,  24'h543123);
        wait_results_drained();
        // oversized offset and set fields give tag 0, zero ways act as one
        set_config(4'd15, 4'd15, 4'd0);
        send_access(OP_LOAD,  24'hFF8000);
        send_access(OP_STORE, 24'h7F8000);
        send_access(OP_LOAD,  24'h000000);
        wait_results_drained();
        write_reg(CFG_WAYS_IN_USE, 4'd15);
        write_reg(CFG_UNUSED_IDX, 4'd9);    // ignored index
        send_access(OP_LOAD,  24'h00FFFF);
        send_access(OP_STORE, 24'hFF0000);
        send_access(OP_LOAD,  24'hFF8000);
    endtask

    task automatic test_random_traffic(input logic [CFG_W-1:0] ob, input logic [CFG_W-1:0] sb,
                                       input logic [CFG_W-1:0] ways, input int sender_pct,
                                       input int recv_pct, input int count);
        int unsigned tag_base;
        wait_results_drained();
        set_config(ob, sb, ways);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = recv_pct;
        tag_base           = $urandom;
        repeat (count) send_random(tag_base);
    endtask

    task automatic test_random_settings(input int sender_pct, input int recv_pct,
                                        input int count);
        logic wide;
        wide = ($urandom_range(0, 3) == 0);
        test_random_traffic(wide ? CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(0, 12)),
                            wide ? CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(0, 10)),
                            wide ? CFG_W'($urandom_range(0, 15)) : CFG_W'($urandom_range(1, 8)),
                            sender_pct, recv_pct, count);
    endtask

    // receiver holds off while the sender keeps offering, input must stall
    task automatic test_output_backpressure();
        int unsigned tag_base;
        wait_results_drained();
        set_config(4'd4, 4'd2, 4'd4);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        tag_base           = $urandom;
        hold_cycles        = 300;
        repeat (60) send_random(tag_base);
    endtask

    initial begin
        for (int r = 0; r < NUM_ROWS; r++)
            for (int w = 0; w < MAX_WAYS; w++) dir_row[r][w] = '0;
        cur_offset_bits = OFFSET_BITS_RST;
        cur_set_bits    = SET_BITS_RST;
        cur_ways        = WAYS_IN_USE_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_lru_order();
        test_config_extremes();
        test_random_traffic(4'd4, 4'd6, 4'd4, 0, 0, 140);
        test_random_traffic(4'd0, 4'd0, 4'd1, 61, 0, 140);
        test_random_traffic(4'd12, 4'd10, 4'd8, 0, 61, 140);
        test_random_traffic(4'd2, 4'd3, 4'd8, 8, 8, 140);
        test_random_settings(0, 0, 100);
        test_random_settings(61, 0, 100);
        test_random_settings(0, 61, 100);
        test_output_backpressure();

        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0 && expected_hits.size() == 0) begin
            $display("set_assoc_lru_tag_directory_top test passed");
        end else begin
            $display("set_assoc_lru_tag_directory_top test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("set_assoc_lru_tag_directory_top test failed");
        $finish;
    end

endmodule
